/* sv/alist_pkg.sv */
package alist_pkg;

    // Default sizing of the list store
    localparam int DEF_CAPACITY     = 256;
    localparam int DEF_PAYLOAD_BITS = 32;

    // Fixed field widths of the request and response channels
    localparam int OPC_W     = 3;
    localparam int POS_W     = 8;
    localparam int VAL_W     = 32;
    localparam int ST_W      = 2;
    localparam int CNT_OUT_W = 9;

    typedef enum logic [OPC_W-1:0] {
        OP_GET    = 3'd0,
        OP_SET    = 3'd1,
        OP_APPEND = 3'd2,
        OP_INSERT = 3'd3,
        OP_REMOVE = 3'd4,
        OP_FIND   = 3'd5,
        OP_CLEAR  = 3'd6
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture request fields, clear result
        logic start;      // set up the store sweep for the current opcode
        logic step;       // advance the sweep by one entry
        logic put_pos;    // write the value at the requested position
        logic put_cnt;    // write the value at the end of the list
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic err_range;
        logic err_full;
        logic out_load;   // move the finished result into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_opcode op;
        logic    pos_lt_cnt;
        logic    pos_le_cnt;
        logic    full;
        logic    sweep_done;
        logic    match;
        logic    out_free;
    } t_stat;

endpackage

/* sv/alist_if.sv */
// Request channel: one list operation per transaction
interface alist_req_if;
    import alist_pkg::*;

    logic             valid;
    logic             ready;
    logic [OPC_W-1:0] opcode;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] item_value;

    modport source (output valid, output opcode, output position, output item_value,
                    input ready);
    modport sink   (input valid, input opcode, input position, input item_value,
                    output ready);
endinterface

// Response channel: one result per request
interface alist_rsp_if;
    import alist_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [VAL_W-1:0]     read_value;
    logic [POS_W-1:0]     found_index;
    logic                 found;
    logic [ST_W-1:0]      status;
    logic [CNT_OUT_W-1:0] entry_count;

    modport source (output valid, output read_value, output found_index, output found,
                    output status, output entry_count, input ready);
    modport sink   (input valid, input read_value, input found_index, input found,
                    input status, input entry_count, output ready);
endinterface

/* sv/alist_dp.sv */
module alist_dp #(
    parameter int CAPACITY     = alist_pkg::DEF_CAPACITY,
    parameter int PAYLOAD_BITS = alist_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  alist_pkg::t_cmd                i_cmd,
    output alist_pkg::t_stat               o_stat,
    input  logic [alist_pkg::OPC_W-1:0]    i_opcode,
    input  logic [alist_pkg::POS_W-1:0]    i_position,
    input  logic [alist_pkg::VAL_W-1:0]    i_item_value,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [alist_pkg::VAL_W-1:0]    o_read_value,
    output logic [alist_pkg::POS_W-1:0]    o_found_index,
    output logic                           o_found,
    output logic [alist_pkg::ST_W-1:0]     o_status,
    output logic [alist_pkg::CNT_OUT_W-1:0] o_entry_count
);
    import alist_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + POS_W;
    localparam int PB = PAYLOAD_BITS;

    // List store, single write port and one registered read port
    logic [PB-1:0] r_mem [CAPACITY];
    logic [PB-1:0] r_rdata;

    // Captured request
    t_opcode        r_op;
    logic [POS_W-1:0] r_pos;
    logic [PB-1:0]  r_key;

    // List length and sweep state
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  r_raddr;
    logic [AW-1:0]  r_waddr;
    logic [CW-1:0]  r_left;
    logic           r_pend;

    // Result being built
    logic [PB-1:0]  r_res_read;
    logic           r_res_found;
    logic [AW-1:0]  r_res_idx;
    t_status        r_status;

    // Output register
    logic                 r_out_valid;
    logic [VAL_W-1:0]     r_out_read;
    logic [POS_W-1:0]     r_out_idx;
    logic                 r_out_found;
    logic [ST_W-1:0]      r_out_status;
    logic [CNT_OUT_W-1:0] r_out_count;

    logic [PB+VAL_W-1:0]     w_key_x;
    logic [XW-1:0]           w_pos_x;
    logic [XW-1:0]           w_cnt_x;
    logic [XW-1:0]           w_cnt_m1;
    logic [XW-1:0]           w_pos_p1;
    logic [XW-1:0]           w_ins_left;
    logic [XW-1:0]           w_rem_left;
    logic                    w_match;
    logic                    w_done;
    logic                    w_rd_en;
    logic                    w_shift_wr;
    logic                    w_we;
    logic [AW-1:0]           w_wa;
    logic [PB-1:0]           w_wd;
    logic                    w_down;
    logic [PB+VAL_W-1:0]     w_read_x;
    logic [AW+POS_W-1:0]     w_idx_x;
    logic [CW+CNT_OUT_W-1:0] w_cnt_out_x;

    // Index arithmetic on a common width
    assign w_key_x    = {{PB{1'b0}}, i_item_value};
    assign w_pos_x    = {{CW{1'b0}}, r_pos};
    assign w_cnt_x    = {{POS_W{1'b0}}, r_count};
    assign w_cnt_m1   = w_cnt_x - XW'(1);
    assign w_pos_p1   = w_pos_x + XW'(1);
    assign w_ins_left = w_cnt_x - w_pos_x;
    assign w_rem_left = w_cnt_x - w_pos_p1;

    // Only a search ends early on a matching entry
    assign w_match = r_pend && (r_op == OP_FIND) && (r_rdata == r_key);
    assign w_done  = (r_left == '0) && !r_pend;
    assign w_rd_en = i_cmd.step && (r_left != '0);
    assign w_down  = (r_op == OP_INSERT);

    assign o_stat.op         = r_op;
    assign o_stat.pos_lt_cnt = w_pos_x < w_cnt_x;
    assign o_stat.pos_le_cnt = w_pos_x <= w_cnt_x;
    assign o_stat.full       = w_cnt_x >= XW'(CAPACITY);
    assign o_stat.sweep_done = w_done;
    assign o_stat.match      = w_match;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    // Write port select: direct writes and the shift stream never overlap in time
    assign w_shift_wr = i_cmd.step && r_pend && (r_op == OP_INSERT || r_op == OP_REMOVE);
    always_comb begin
        w_we = 1'b0;
        w_wa = r_waddr;
        w_wd = r_rdata;
        priority if (i_cmd.put_pos) begin
            w_we = 1'b1;
            w_wa = w_pos_x[AW-1:0];
            w_wd = r_key;
        end else if (i_cmd.put_cnt) begin
            w_we = 1'b1;
            w_wa = w_cnt_x[AW-1:0];
            w_wd = r_key;
        end else if (w_shift_wr) begin
            w_we = 1'b1;
        end
    end

    // Store access
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[r_raddr];
        end
    end

    // Request capture and result building
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= t_opcode'(i_opcode);
            r_pos       <= i_position;
            r_key       <= w_key_x[PB-1:0];
            r_res_read  <= '0;
            r_res_found <= 1'b0;
            r_res_idx   <= '0;
            r_status    <= ST_OK;
        end else begin
            if (i_cmd.err_range) begin
                r_status <= ST_RANGE;
            end
            if (i_cmd.err_full) begin
                r_status <= ST_FULL;
            end
            if (i_cmd.step && r_pend && r_op == OP_GET) begin
                r_res_read <= r_rdata;
            end
            if (i_cmd.step && w_match && r_op == OP_FIND) begin
                r_res_found <= 1'b1;
                r_res_idx   <= r_waddr;
            end
        end
    end

    // Sweep counters and list length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_left  <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end

            if (i_cmd.start) begin
                r_pend <= 1'b0;
                unique case (r_op)
                    OP_GET: begin
                        r_raddr <= w_pos_x[AW-1:0];
                        r_waddr <= '0;
                        r_left  <= CW'(1);
                    end
                    OP_INSERT: begin
                        r_raddr <= w_cnt_m1[AW-1:0];
                        r_waddr <= w_cnt_x[AW-1:0];
                        r_left  <= w_ins_left[CW-1:0];
                    end
                    OP_REMOVE: begin
                        r_raddr <= w_pos_p1[AW-1:0];
                        r_waddr <= w_pos_x[AW-1:0];
                        r_left  <= w_rem_left[CW-1:0];
                    end
                    OP_FIND: begin
                        r_raddr <= '0;
                        r_waddr <= '0;
                        r_left  <= r_count;
                    end
                    default: begin
                        r_left <= '0;
                    end
                endcase
            end else if (i_cmd.step) begin
                r_pend <= w_rd_en;
                if (w_rd_en) begin
                    r_raddr <= w_down ? r_raddr - AW'(1) : r_raddr + AW'(1);
                    r_left  <= r_left - CW'(1);
                end
                if (r_pend) begin
                    r_waddr <= w_down ? r_waddr - AW'(1) : r_waddr + AW'(1);
                end
            end
        end
    end

    // Output register, reloaded as soon as the previous transaction leaves
    assign w_read_x    = {{VAL_W{1'b0}}, r_res_read};
    assign w_idx_x     = {{POS_W{1'b0}}, r_res_idx};
    assign w_cnt_out_x = {{CNT_OUT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_read   <= w_read_x[VAL_W-1:0];
            r_out_idx    <= w_idx_x[POS_W-1:0];
            r_out_found  <= r_res_found;
            r_out_status <= r_status;
            r_out_count  <= w_cnt_out_x[CNT_OUT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out_read;
    assign o_found_index = r_out_idx;
    assign o_found       = r_out_found;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

endmodule

/* sv/alist_ctrl.sv */
module alist_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  alist_pkg::t_stat i_stat,
    output alist_pkg::t_cmd  o_cmd
);
    import alist_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_DONE;
                unique case (i_stat.op)
                    OP_GET, OP_REMOVE: begin
                        if (i_stat.pos_lt_cnt) begin
                            o_cmd.start = 1'b1;
                            n_state     = S_SWEEP;
                        end else begin
                            o_cmd.err_range = 1'b1;
                        end
                    end
                    OP_SET: begin
                        if (i_stat.pos_lt_cnt) begin
                            o_cmd.put_pos = 1'b1;
                        end else begin
                            o_cmd.err_range = 1'b1;
                        end
                    end
                    OP_APPEND: begin
                        if (i_stat.full) begin
                            o_cmd.err_full = 1'b1;
                        end else begin
                            o_cmd.put_cnt = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                        end
                    end
                    OP_INSERT: begin
                        priority if (!i_stat.pos_le_cnt) begin
                            o_cmd.err_range = 1'b1;
                        end else if (i_stat.full) begin
                            o_cmd.err_full = 1'b1;
                        end else begin
                            o_cmd.start = 1'b1;
                            n_state     = S_SWEEP;
                        end
                    end
                    OP_FIND: begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SWEEP;
                    end
                    OP_CLEAR: begin
                        o_cmd.cnt_clr = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_SWEEP: begin
                o_cmd.step = 1'b1;
                priority if (i_stat.match) begin
                    n_state = S_DONE;
                end else if (i_stat.sweep_done) begin
                    n_state = S_DONE;
                    if (i_stat.op == OP_INSERT) begin
                        o_cmd.put_pos = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                    end
                    if (i_stat.op == OP_REMOVE) begin
                        o_cmd.cnt_dec = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/array_list_engine.sv */
// Ordered list engine: a store of CAPACITY words of PAYLOAD_BITS bits and a count.
// Requests arrive on i_req (opcode, position, item_value), one per transaction;
// each produces exactly one response transaction on o_rsp with the word read,
// the find outcome, a status code and the entry count after the operation.
// Set, append, clear and any rejected request finish without a sweep; get reads
// one entry; insert and remove shift the entries between position and the end
// of the list; find searches from entry 0 and stops at the first match. Insert,
// remove and find walk the store one entry per cycle through its single write
// port and registered read port.
// One request is in progress at a time; i_req.ready is high while idle.
// The finished result sits in an output register, so a new request is taken
// while a response waits; if o_rsp is stalled the engine holds its next result
// until the register frees. Reset empties the list (count zero) and drops any
// pending response; store contents are not cleared and never read past count.
module array_list_engine #(
    parameter int CAPACITY     = alist_pkg::DEF_CAPACITY,
    parameter int PAYLOAD_BITS = alist_pkg::DEF_PAYLOAD_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    alist_req_if.sink   i_req,
    alist_rsp_if.source o_rsp
);
    import alist_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    alist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    alist_dp #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_opcode      (i_req.opcode),
        .i_position    (i_req.position),
        .i_item_value  (i_req.item_value),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_read_value  (o_rsp.read_value),
        .o_found_index (o_rsp.found_index),
        .o_found       (o_rsp.found),
        .o_status      (o_rsp.status),
        .o_entry_count (o_rsp.entry_count)
    );

endmodule

/* sv/alist_checker.sv */
module alist_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_req_valid,
    input logic                           i_req_ready,
    input logic                           i_rsp_valid,
    input logic                           i_rsp_ready,
    input logic [alist_pkg::VAL_W-1:0]    i_read_value,
    input logic [alist_pkg::POS_W-1:0]    i_found_index,
    input logic                           i_found,
    input logic [alist_pkg::ST_W-1:0]     i_status,
    input logic [alist_pkg::CNT_OUT_W-1:0] i_entry_count
);
    import alist_pkg::*;

    // No response is left pending by reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    // A stalled response holds its contents
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_read_value)
            && $stable(i_found_index) && $stable(i_found) && $stable(i_status)
            && $stable(i_entry_count))
        else $error("stalled response changed");

    // Only one request in progress: the engine is busy right after accepting one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while previous one still in progress");

    // A rejected request reports nothing but its status and the count
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status != ST_OK |-> i_read_value == '0 && !i_found
            && i_found_index == '0)
        else $error("error response carries data");

endmodule

bind array_list_engine alist_checker u_alist_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_read_value  (o_rsp.read_value),
    .i_found_index (o_rsp.found_index),
    .i_found       (o_rsp.found),
    .i_status      (o_rsp.status),
    .i_entry_count (o_rsp.entry_count)
);
